@@ rtl/core/pdwp_pkg.sv @@
// ----------------------------------------------------------------------------
// pdwp_pkg
// Shared widths, register codes, pose type and fixed-point helpers for the
// pixel-to-world point pipeline.
// ----------------------------------------------------------------------------
package pdwp_pkg;

  // Field widths of the detection and point channels.
  localparam int PixW   = 12;
  localparam int RangeW = 16;
  localparam int PosW   = 32;
  localparam int QuatW  = 16;
  localparam int CfgW   = 16;

  // Camera mount pose: rotation entries in Q.14, translation in mm.
  localparam int MountCos = 14189;
  localparam int MountSin = 8191;
  localparam int MountTx  = 1000;
  localparam int MountTz  = 1200;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    REG_FOCAL_X,
    REG_FOCAL_Y,
    REG_CENTRE_X,
    REG_CENTRE_Y
  } cfg_reg_t;

  // Vehicle pose carried along the pipeline.
  typedef struct packed {
    logic signed [QuatW-1:0] qx;
    logic signed [QuatW-1:0] qy;
    logic signed [QuatW-1:0] qz;
    logic signed [QuatW-1:0] qw;
    logic signed [PosW-1:0]  tx;
    logic signed [PosW-1:0]  ty;
    logic signed [PosW-1:0]  tz;
  } pose_t;

  // A clipped coordinate and whether clipping happened.
  typedef struct packed {
    logic                   sat;
    logic signed [PosW-1:0] val;
  } clip_t;

  // Drop 14 fraction bits, rounding half away from zero.
  function automatic logic signed [63:0] rs14(input logic signed [63:0] v);
    logic signed [63:0] bias;
    bias = v[63] ? 64'sd8191 : 64'sd8192;
    return (v + bias) >>> 14;
  endfunction

  // Saturate a 44-bit value to 32 bits signed.
  function automatic clip_t clip44(input logic signed [43:0] v);
    clip_t c;
    if (v > 44'sh0007FFFFFFF) begin
      c.sat = 1'b1;
      c.val = 32'sh7FFFFFFF;
    end else if (v < 44'shFFF80000000) begin
      c.sat = 1'b1;
      c.val = 32'sh80000000;
    end else begin
      c.sat = 1'b0;
      c.val = v[31:0];
    end
    return c;
  endfunction

endpackage

@@ rtl/core/pdwp_if.sv @@
// ----------------------------------------------------------------------------
// pdwp_if
// Valid/ready channels for detections in and world points out.
// ----------------------------------------------------------------------------
interface pdwp_det_if;
  logic                                valid;
  logic                                ready;
  logic [pdwp_pkg::PixW-1:0]           pixel_col;
  logic [pdwp_pkg::PixW-1:0]           pixel_row;
  logic [pdwp_pkg::RangeW-1:0]         range_mm;
  logic signed [pdwp_pkg::PosW-1:0]    odom_x;
  logic signed [pdwp_pkg::PosW-1:0]    odom_y;
  logic signed [pdwp_pkg::PosW-1:0]    odom_z;
  logic signed [pdwp_pkg::QuatW-1:0]   odom_qx;
  logic signed [pdwp_pkg::QuatW-1:0]   odom_qy;
  logic signed [pdwp_pkg::QuatW-1:0]   odom_qz;
  logic signed [pdwp_pkg::QuatW-1:0]   odom_qw;

  modport source (
    output valid, pixel_col, pixel_row, range_mm, odom_x, odom_y, odom_z,
           odom_qx, odom_qy, odom_qz, odom_qw,
    input  ready
  );
  modport sink (
    input  valid, pixel_col, pixel_row, range_mm, odom_x, odom_y, odom_z,
           odom_qx, odom_qy, odom_qz, odom_qw,
    output ready
  );
endinterface

interface pdwp_pt_if;
  logic                             valid;
  logic                             ready;
  logic signed [pdwp_pkg::PosW-1:0] world_x;
  logic signed [pdwp_pkg::PosW-1:0] world_y;
  logic signed [pdwp_pkg::PosW-1:0] world_z;
  logic                             saturated;

  modport source (output valid, world_x, world_y, world_z, saturated, input ready);
  modport sink (input valid, world_x, world_y, world_z, saturated, output ready);
endinterface

@@ rtl/core/pixel_depth_to_world_point_top.sv @@
// Throughput: one beat per cycle; the whole pipeline holds when the output
// register is full and not taken. The 32-stage restoring divider sets depth.
// Reset (synchronous, active high) clears all valid bits and loads the
// default focal lengths and principal point.
// ----------------------------------------------------------------------------
// pixel_depth_to_world_point_top
// Pinhole back-projection of a detection followed by the camera mount and
// vehicle rigid transforms, saturated to 32-bit world coordinates.
// ----------------------------------------------------------------------------
module pixel_depth_to_world_point_top #(
  parameter int PIXEL_BITS = 12
) (
  input  logic               clk,
  input  logic               rst,
  pdwp_det_if.sink           det,
  pdwp_pt_if.source          pt,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_data
);

  localparam int UseBits = (PIXEL_BITS < pdwp_pkg::PixW) ? PIXEL_BITS : pdwp_pkg::PixW;
  localparam logic [pdwp_pkg::PixW-1:0] PixMask =
    pdwp_pkg::PixW'((64'd1 << UseBits) - 64'd1);
  localparam int DivSteps = 32;

  // Configuration registers.
  logic [15:0] focal_x, focal_y, centre_x, centre_y;
  logic [15:0] fx_eff, fy_eff;

  always_ff @(posedge clk) begin
    if (rst) begin
      focal_x  <= 16'd16384;
      focal_y  <= 16'd16384;
      centre_x <= 16'd10240;
      centre_y <= 16'd7680;
    end else if (cfg_we) begin
      case (pdwp_pkg::cfg_reg_t'(cfg_index))
        pdwp_pkg::REG_FOCAL_X:  focal_x  <= cfg_data;
        pdwp_pkg::REG_FOCAL_Y:  focal_y  <= cfg_data;
        pdwp_pkg::REG_CENTRE_X: centre_x <= cfg_data;
        pdwp_pkg::REG_CENTRE_Y: centre_y <= cfg_data;
        default: ;
      endcase
    end
  end

  // A zero focal length divides as one.
  assign fx_eff = (focal_x == 16'd0) ? 16'd1 : focal_x;
  assign fy_eff = (focal_y == 16'd0) ? 16'd1 : focal_y;

  // Global advance: the pipe moves when the output register is empty or being taken.
  logic en;
  logic v1, v2, v_e, v_f, v_g, v_h, v_i, v_out;
  logic [DivSteps:0] vd;

  assign en        = !v_out || pt.ready;
  assign det.ready = en && !rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0; v2 <= 1'b0; vd <= '0;
      v_e <= 1'b0; v_f <= 1'b0; v_g <= 1'b0;
      v_h <= 1'b0; v_i <= 1'b0; v_out <= 1'b0;
    end else if (en) begin
      v1    <= det.valid;
      v2    <= v1;
      vd    <= {vd[DivSteps-1:0], v2};
      v_e   <= vd[DivSteps];
      v_f   <= v_e;
      v_g   <= v_f;
      v_h   <= v_g;
      v_i   <= v_h;
      v_out <= v_i;
    end
  end

  // Stage 1: pixel offsets from the principal point, Q.4.
  logic [pdwp_pkg::PixW-1:0] col_m, row_m;
  logic signed [17:0] dc1, dr1;
  logic [15:0] rng1;
  pdwp_pkg::pose_t pose1;

  assign col_m = det.pixel_col & PixMask;
  assign row_m = det.pixel_row & PixMask;

  always_ff @(posedge clk) begin
    if (en) begin
      dc1   <= $signed({2'b00, col_m, 4'b0000}) - $signed({2'b00, centre_x});
      dr1   <= $signed({2'b00, row_m, 4'b0000}) - $signed({2'b00, centre_y});
      rng1  <= det.range_mm;
      pose1 <= '{qx: det.odom_qx, qy: det.odom_qy, qz: det.odom_qz, qw: det.odom_qw,
                 tx: det.odom_x, ty: det.odom_y, tz: det.odom_z};
    end
  end

  // Stage 2: offsets scaled by range.
  logic signed [34:0] py2, pz2;
  logic [15:0] rng2;
  pdwp_pkg::pose_t pose2;

  always_ff @(posedge clk) begin
    if (en) begin
      py2   <= dr1 * $signed({1'b0, rng1});
      pz2   <= dc1 * $signed({1'b0, rng1});
      rng2  <= rng1;
      pose2 <= pose1;
    end
  end

  // Stage 3 and divider: sign and magnitude, then one quotient bit per stage.
  logic [15:0] rem_y [0:DivSteps];
  logic [15:0] rem_z [0:DivSteps];
  logic [31:0] dq_y  [0:DivSteps];
  logic [31:0] dq_z  [0:DivSteps];
  logic        ng_y  [0:DivSteps];
  logic        ng_z  [0:DivSteps];
  logic [15:0] rng_d [0:DivSteps];
  pdwp_pkg::pose_t pose_d [0:DivSteps];

  always_ff @(posedge clk) begin
    if (en) begin
      rem_y[0]  <= 16'd0;
      rem_z[0]  <= 16'd0;
      dq_y[0]   <= py2[34] ? 32'(-py2) : py2[31:0];
      dq_z[0]   <= pz2[34] ? 32'(-pz2) : pz2[31:0];
      ng_y[0]   <= py2[34];
      ng_z[0]   <= pz2[34];
      rng_d[0]  <= rng2;
      pose_d[0] <= pose2;
    end
  end

  for (genvar k = 0; k < DivSteps; k++) begin : g_div
    logic [16:0] try_y, try_z;
    logic        ge_y, ge_z;

    // Shift in the next dividend bit and subtract if the divisor fits.
    always_comb begin
      try_y = {rem_y[k], dq_y[k][31]};
      try_z = {rem_z[k], dq_z[k][31]};
      ge_y  = try_y >= {1'b0, fy_eff};
      ge_z  = try_z >= {1'b0, fx_eff};
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_y[k+1]  <= ge_y ? 16'(try_y - {1'b0, fy_eff}) : try_y[15:0];
        rem_z[k+1]  <= ge_z ? 16'(try_z - {1'b0, fx_eff}) : try_z[15:0];
        dq_y[k+1]   <= {dq_y[k][30:0], ge_y};
        dq_z[k+1]   <= {dq_z[k][30:0], ge_z};
        ng_y[k+1]   <= ng_y[k];
        ng_z[k+1]   <= ng_z[k];
        rng_d[k+1]  <= rng_d[k];
        pose_d[k+1] <= pose_d[k];
      end
    end
  end

  // Stage E: signed camera point with clipping; quaternion products.
  logic signed [32:0] sq_y, sq_z;
  pdwp_pkg::clip_t cl_y, cl_z;
  pdwp_pkg::pose_t pd;

  assign pd   = pose_d[DivSteps];
  assign sq_y = ng_y[DivSteps] ? -$signed({1'b0, dq_y[DivSteps]}) : $signed({1'b0, dq_y[DivSteps]});
  assign sq_z = ng_z[DivSteps] ? -$signed({1'b0, dq_z[DivSteps]}) : $signed({1'b0, dq_z[DivSteps]});
  assign cl_y = pdwp_pkg::clip44(44'(sq_y));
  assign cl_z = pdwp_pkg::clip44(44'(sq_z));

  logic signed [31:0] c1_e, c2_e;
  logic signed [31:0] xx_e, yy_e, zz_e, xy_e, xz_e, yz_e, xw_e, yw_e, zw_e;
  logic sat_e;
  logic [15:0] rng_e;
  pdwp_pkg::pose_t pose_e;

  always_ff @(posedge clk) begin
    if (en) begin
      c1_e   <= cl_y.val;
      c2_e   <= cl_z.val;
      sat_e  <= cl_y.sat | cl_z.sat;
      rng_e  <= rng_d[DivSteps];
      pose_e <= pd;
      xx_e   <= pd.qx * pd.qx;
      yy_e   <= pd.qy * pd.qy;
      zz_e   <= pd.qz * pd.qz;
      xy_e   <= pd.qx * pd.qy;
      xz_e   <= pd.qx * pd.qz;
      yz_e   <= pd.qy * pd.qz;
      xw_e   <= pd.qx * pd.qw;
      yw_e   <= pd.qy * pd.qw;
      zw_e   <= pd.qz * pd.qw;
    end
  end

  // Stage F: mount rotation products and vehicle rotation matrix in Q.14.
  logic signed [63:0] one_q, e_m [0:8];
  logic signed [47:0] rng_x, c2_x;

  assign one_q = 64'sd1 <<< 28;
  assign rng_x = $signed({32'd0, rng_e});
  assign c2_x  = 48'(c2_e);

  always_comb begin
    e_m[0] = one_q - 64'sd2 * (64'(yy_e) + 64'(zz_e));
    e_m[1] = 64'sd2 * (64'(xy_e) - 64'(zw_e));
    e_m[2] = 64'sd2 * (64'(xz_e) + 64'(yw_e));
    e_m[3] = 64'sd2 * (64'(xy_e) + 64'(zw_e));
    e_m[4] = one_q - 64'sd2 * (64'(xx_e) + 64'(zz_e));
    e_m[5] = 64'sd2 * (64'(yz_e) - 64'(xw_e));
    e_m[6] = 64'sd2 * (64'(xz_e) - 64'(yw_e));
    e_m[7] = 64'sd2 * (64'(yz_e) + 64'(xw_e));
    e_m[8] = one_q - 64'sd2 * (64'(xx_e) + 64'(yy_e));
  end

  logic signed [47:0] a0_f, b0_f, a2_f, b2_f;
  logic signed [31:0] c1_f;
  logic signed [19:0] r_f [0:8];
  logic sat_f;
  pdwp_pkg::pose_t pose_f;

  always_ff @(posedge clk) begin
    if (en) begin
      a0_f   <= rng_x * 48'(pdwp_pkg::MountCos);
      b0_f   <= rng_x * 48'(pdwp_pkg::MountSin);
      a2_f   <= c2_x * 48'(pdwp_pkg::MountCos);
      b2_f   <= c2_x * 48'(pdwp_pkg::MountSin);
      c1_f   <= c1_e;
      sat_f  <= sat_e;
      pose_f <= pose_e;
      for (int i = 0; i < 9; i++) begin
        r_f[i] <= 20'(pdwp_pkg::rs14(e_m[i]));
      end
    end
  end

  // Stage G: point in the vehicle frame.
  logic signed [34:0] m_g [0:2];
  logic signed [19:0] r_g [0:8];
  logic sat_g;
  pdwp_pkg::pose_t pose_g;

  always_ff @(posedge clk) begin
    if (en) begin
      m_g[0] <= 35'(pdwp_pkg::rs14(64'(a0_f) + 64'(b2_f)) + 64'(pdwp_pkg::MountTx));
      m_g[1] <= 35'(c1_f);
      m_g[2] <= 35'(pdwp_pkg::rs14(64'(a2_f) - 64'(b0_f)) + 64'(pdwp_pkg::MountTz));
      r_g    <= r_f;
      sat_g  <= sat_f;
      pose_g <= pose_f;
    end
  end

  // Stage H: vehicle rotation products.
  logic signed [54:0] p_h [0:8];
  logic sat_h;
  pdwp_pkg::pose_t pose_h;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 9; i++) begin
        p_h[i] <= r_g[i] * m_g[i % 3];
      end
      sat_h  <= sat_g;
      pose_h <= pose_g;
    end
  end

  // Stage I: row sums, rounding and vehicle translation.
  logic signed [63:0] t_h [0:2];
  logic signed [43:0] w_i [0:2];
  logic sat_i;

  assign t_h[0] = 64'(pose_h.tx);
  assign t_h[1] = 64'(pose_h.ty);
  assign t_h[2] = 64'(pose_h.tz);

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        w_i[i] <= 44'(pdwp_pkg::rs14(64'(p_h[3*i]) + 64'(p_h[3*i+1]) + 64'(p_h[3*i+2]))
                      + t_h[i]);
      end
      sat_i <= sat_h;
    end
  end

  // Output register: clip the world point.
  pdwp_pkg::clip_t cw0, cw1, cw2;
  logic signed [31:0] wx_o, wy_o, wz_o;
  logic sat_o;

  assign cw0 = pdwp_pkg::clip44(w_i[0]);
  assign cw1 = pdwp_pkg::clip44(w_i[1]);
  assign cw2 = pdwp_pkg::clip44(w_i[2]);

  always_ff @(posedge clk) begin
    if (en) begin
      wx_o  <= cw0.val;
      wy_o  <= cw1.val;
      wz_o  <= cw2.val;
      sat_o <= sat_i | cw0.sat | cw1.sat | cw2.sat;
    end
  end

  assign pt.valid     = v_out;
  assign pt.world_x   = wx_o;
  assign pt.world_y   = wy_o;
  assign pt.world_z   = wz_o;
  assign pt.saturated = sat_o;

endmodule

@@ tb/pixel_depth_to_world_point_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// pixel_depth_to_world_point_checker
// Watches the detection and point channels and the register port, predicts
// each world point from the accepted detection and the current focal and
// principal point settings, and compares the points in order, field by field.
// ----------------------------------------------------------------------------
module pixel_depth_to_world_point_checker (
  input  logic        clk,
  input  logic        rst,
  pdwp_det_if         det,
  pdwp_pt_if          pt,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  output int          fail_count,
  output int          points_pending
);
  import pdwp_pkg::*;

  typedef struct {
    logic signed [PosW-1:0] x;
    logic signed [PosW-1:0] y;
    logic signed [PosW-1:0] z;
    logic                   sat;
  } world_point_t;

  typedef longint vec3_t[3];
  typedef longint quat_t[4];

  logic [CfgW-1:0] focal_x, focal_y, centre_x, centre_y;
  world_point_t    point_expected_q[$];

  assign points_pending = point_expected_q.size();

  // Drop 14 fraction bits, halves rounded away from zero.
  function automatic longint round_q14(longint v);
    longint mag;
    mag = (v < 0) ? -v : v;
    mag = (mag + 64'sd8192) >>> 14;
    return (v < 0) ? -mag : mag;
  endfunction

  // Clip to 32 bits signed and note whether clipping happened.
  function automatic longint clip_word(longint v, inout bit flag);
    if (v > 64'sd2147483647) begin
      flag = 1'b1;
      return 64'sd2147483647;
    end
    if (v < -64'sd2147483648) begin
      flag = 1'b1;
      return -64'sd2147483648;
    end
    return v;
  endfunction

  // Rotate by an unnormalized quaternion (Q2.14) and translate.
  function automatic vec3_t rotate_translate(quat_t q, vec3_t t, vec3_t p);
    longint qx, qy, qz, qw, one;
    longint e[9];
    longint r[9];
    vec3_t  o;
    qx = q[0]; qy = q[1]; qz = q[2]; qw = q[3];
    one = 64'sd1 << 28;
    e[0] = one - 2*qy*qy - 2*qz*qz;
    e[1] = 2*qx*qy - 2*qz*qw;
    e[2] = 2*qx*qz + 2*qy*qw;
    e[3] = 2*qx*qy + 2*qz*qw;
    e[4] = one - 2*qx*qx - 2*qz*qz;
    e[5] = 2*qy*qz - 2*qx*qw;
    e[6] = 2*qx*qz - 2*qy*qw;
    e[7] = 2*qy*qz + 2*qx*qw;
    e[8] = one - 2*qx*qx - 2*qy*qy;
    for (int i = 0; i < 9; i++) r[i] = round_q14(e[i]);
    for (int i = 0; i < 3; i++)
      o[i] = round_q14(r[3*i]*p[0] + r[3*i+1]*p[1] + r[3*i+2]*p[2]) + t[i];
    return o;
  endfunction

  // Back-project one detection and carry it through mount and vehicle poses.
  function automatic world_point_t predict_world_point();
    longint       col, row, rng, fx, fy, dc, dr;
    bit           sat;
    vec3_t        cam, mid, world, mount_t, odom_t;
    quat_t        mount_q, odom_q;
    world_point_t p;
    sat = 1'b0;
    col = longint'(det.pixel_col);
    row = longint'(det.pixel_row);
    rng = longint'(det.range_mm);
    fx  = (focal_x == '0) ? 1 : longint'(focal_x);
    fy  = (focal_y == '0) ? 1 : longint'(focal_y);
    dc  = col*16 - longint'(centre_x);
    dr  = row*16 - longint'(centre_y);
    cam[0] = rng;
    cam[1] = clip_word(dr*rng / fy, sat);
    cam[2] = clip_word(dc*rng / fx, sat);
    mount_q = '{0, 4240, 0, 15826};
    mount_t = '{1000, 0, 1200};
    odom_q  = '{longint'(det.odom_qx), longint'(det.odom_qy),
                longint'(det.odom_qz), longint'(det.odom_qw)};
    odom_t  = '{longint'(det.odom_x), longint'(det.odom_y), longint'(det.odom_z)};
    mid   = rotate_translate(mount_q, mount_t, cam);
    world = rotate_translate(odom_q, odom_t, mid);
    p.x   = clip_word(world[0], sat);
    p.y   = clip_word(world[1], sat);
    p.z   = clip_word(world[2], sat);
    p.sat = sat;
    return p;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("%0t mismatch %s: got %0d, expected %0d", $realtime, what, got, want);
    fail_count++;
  endtask

  initial fail_count = 0;

  // Register shadow; writes must land only while pipeline idle (unchecked).
  always @(posedge clk) begin
    if (rst) begin
      focal_x  <= 16'd16384;
      focal_y  <= 16'd16384;
      centre_x <= 16'd10240;
      centre_y <= 16'd7680;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_FOCAL_X:  focal_x  <= cfg_data;
        REG_FOCAL_Y:  focal_y  <= cfg_data;
        REG_CENTRE_X: centre_x <= cfg_data;
        REG_CENTRE_Y: centre_y <= cfg_data;
        default: ;
      endcase
    end
  end

  // Predict on every accepted detection beat, compare every point beat.
  always @(posedge clk) begin
    world_point_t want;
    if (!rst) begin
      if (det.valid && det.ready) point_expected_q.push_back(predict_world_point());
      if (pt.valid && pt.ready) begin
        if (point_expected_q.size() == 0) begin
          $display("%0t point beat with no detection waiting", $realtime);
          fail_count++;
        end else begin
          want = point_expected_q.pop_front();
          if (pt.world_x !== want.x) report_mismatch("world_x", pt.world_x, want.x);
          if (pt.world_y !== want.y) report_mismatch("world_y", pt.world_y, want.y);
          if (pt.world_z !== want.z) report_mismatch("world_z", pt.world_z, want.z);
          if (pt.saturated !== want.sat)
            report_mismatch("saturated", pt.saturated, want.sat);
        end
      end
    end
  end

endmodule

@@ tb/pixel_depth_to_world_point_top_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// pixel_depth_to_world_point_top_tb
// Drives detections through the pixel-to-world pipeline under several focal
// and principal point settings and idling and stall patterns; a checker predicts and
// compares every world point.
// ----------------------------------------------------------------------------
module pixel_depth_to_world_point_top_tb;
  import pdwp_pkg::*;

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [15:0] cfg_data;
  int          fail_count;
  int          points_pending;
  int          idle_pct;
  int          stall_pct;

  pdwp_det_if det ();
  pdwp_pt_if  pt ();

  pixel_depth_to_world_point_top uut (
    .clk(clk), .rst(rst), .det(det), .pt(pt),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  pixel_depth_to_world_point_checker checker_i (
    .clk(clk), .rst(rst), .det(det), .pt(pt),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .fail_count(fail_count), .points_pending(points_pending)
  );

  always begin
    clk = 1'b1;
    #2;
    clk = 1'b0;
    #2;
  end

  // Point receiver stalls at the phase's rate.
  always @(posedge clk) pt.ready <= ($urandom_range(99) >= stall_pct);

  // Hold one detection beat until it is taken, after optional idle cycles.
  task automatic send_detection(int col, int row, int rng, int x, int y, int z,
                                int qx, int qy, int qz, int qw);
    while ($urandom_range(99) < idle_pct) begin
      det.valid <= 1'b0;
      @(posedge clk);
    end
    det.valid     <= 1'b1;
    det.pixel_col <= PixW'(col);
    det.pixel_row <= PixW'(row);
    det.range_mm  <= RangeW'(rng);
    det.odom_x    <= x;
    det.odom_y    <= y;
    det.odom_z    <= z;
    det.odom_qx   <= QuatW'(qx);
    det.odom_qy   <= QuatW'(qy);
    det.odom_qz   <= QuatW'(qz);
    det.odom_qw   <= QuatW'(qw);
    do @(posedge clk); while (!det.ready);
  endtask

  function automatic int rand_quat();
    return int'($urandom_range(32768)) - 16384;
  endfunction

  // Positions are mostly near the origin, sometimes anywhere in 32 bits.
  function automatic int rand_pos();
    if ($urandom_range(3) == 0) return int'($urandom());
    return int'($urandom_range(200000)) - 100000;
  endfunction

  task automatic send_random_detection();
    int rng;
    rng = ($urandom_range(3) == 0) ? int'($urandom_range(65535))
                                   : int'($urandom_range(20000));
    if ($urandom_range(1) == 0)
      // Rotation mostly about z, the common vehicle case, not always of unit length.
      send_detection(int'($urandom()), int'($urandom()), rng,
                     rand_pos(), rand_pos(), rand_pos(),
                     int'($urandom_range(400)) - 200,
                     int'($urandom_range(400)) - 200,
                     rand_quat(), 16000 + int'($urandom_range(384)));
    else
      send_detection(int'($urandom()), int'($urandom()), rng,
                     rand_pos(), rand_pos(), rand_pos(),
                     rand_quat(), rand_quat(), rand_quat(), rand_quat());
  endtask

  task automatic write_register(cfg_reg_t idx, logic [15:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
  endtask

  task automatic write_settings(logic [15:0] fx, logic [15:0] fy,
                                logic [15:0] cx, logic [15:0] cy);
    write_register(REG_FOCAL_X, fx);
    write_register(REG_FOCAL_Y, fy);
    write_register(REG_CENTRE_X, cx);
    write_register(REG_CENTRE_Y, cy);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Drain every outstanding point, then let the pipeline settle.
  task automatic drain();
    det.valid <= 1'b0;
    while (points_pending != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  initial begin
    rst           <= 1'b1;
    cfg_we        <= 1'b0;
    cfg_index     <= '0;
    cfg_data      <= '0;
    det.valid     <= 1'b0;
    det.pixel_col <= '0;
    det.pixel_row <= '0;
    det.range_mm  <= '0;
    det.odom_x    <= '0;
    det.odom_y    <= '0;
    det.odom_z    <= '0;
    det.odom_qx   <= '0;
    det.odom_qy   <= '0;
    det.odom_qz   <= '0;
    det.odom_qw   <= '0;
    idle_pct  = 0;
    stall_pct = 0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed beats under the reset settings.
    send_detection(0, 0, 0, 0, 0, 0, 0, 0, 0, 16384);
    send_detection(4095, 4095, 65535, 0, 0, 0, 0, 0, 0, 16384);
    send_detection(0, 4095, 65535, 0, 0, 0, 0, 0, 0, 16384);
    send_detection(4095, 0, 1000, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF,
                   0, 0, 0, 16384);
    send_detection(640, 480, 5000, 32'h80000000, 32'h80000000, 32'h80000000,
                   0, 0, 0, 16384);
    send_detection(100, 200, 3000, 0, 0, 0, 16384, 0, 0, 0);
    send_detection(100, 200, 3000, 0, 0, 0, 0, 16384, 0, 0);
    send_detection(100, 200, 3000, 0, 0, 0, 0, 0, 16384, 0);
    send_detection(100, 200, 3000, 0, 0, 0, -16384, -16384, -16384, -16384);
    // Mostly unnormalized quaternions, both extreme and tiny.
    send_detection(3000, 1000, 40000, 0, 0, 0, 16384, 16384, 16384, 16384);
    send_detection(3000, 1000, 40000, 0, 0, 0, 0, 0, 0, 0);
    send_detection(4095, 4095, 65535, 32'h7FFFFFF0, 32'h80000010, 5,
                   -16384, 16384, -16384, 16384);
    send_detection(640, 480, 12345, 12345678, -12345678, 999, 0, 0, 2896, 16125);
    send_detection(2048, 2048, 1, -1, 1, -1, 1, 1, 1, 1);

    for (int phase = 0; phase < 6; phase++) begin
      case (phase % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 59; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 59; end
        default: begin idle_pct = 10; stall_pct = 10; end
      endcase
      for (int n = 0; n < 250; n++) send_random_detection();
      drain();
      case (phase)
        // Largest focal lengths and principal point.
        0: write_settings(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        // Zero focal lengths act as one; centre at the origin overflows easily.
        1: write_settings(16'h0000, 16'h0000, 16'h0000, 16'h0000);
        2: write_settings(16'h0001, 16'h0001, 16'h8000, 16'h7FFF);
        3: write_settings(16'($urandom()), 16'($urandom()),
                          16'($urandom()), 16'($urandom()));
        4: write_settings(16'd14000, 16'd14000, 16'd10240, 16'd7680);
        default: ;
      endcase
    end

    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // Run limit, far beyond the slowest correct run.
  initial begin
    #2ms;
    $display("status: fail");
    $finish;
  end

endmodule

@@ sim.f @@
rtl/core/pdwp_pkg.sv
rtl/core/pdwp_if.sv
rtl/core/pixel_depth_to_world_point_top.sv
tb/pixel_depth_to_world_point_checker.sv
tb/pixel_depth_to_world_point_top_tb.sv
